FILE: rtl/xoroshiro_prng_ranged_defines.svh
// Assertion macros shared by the xoroshiro PRNG RTL.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef XOROSHIRO_PRNG_RANGED_DEFINES_SVH
`define XOROSHIRO_PRNG_RANGED_DEFINES_SVH

// same-cycle implication
`define XPR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define XPR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: rtl/xpr_pkg.sv
// Package for the xoroshiro PRNG: opcodes, constants, unit status struct.
// No dependencies.
package xpr_pkg;

   localparam int WORD_W     = 64;
   localparam int FRAC_W     = 53;
   localparam int FRAC_SHIFT = WORD_W - FRAC_W;
   localparam int CNT_W      = $clog2(WORD_W);

   localparam logic [WORD_W-1:0] GOLDEN  = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_W-1:0] MIX_M1  = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_M2  = 64'h94D0_49BB_1331_11EB;
   localparam logic [WORD_W-1:0] RESET_A = 64'h0000_0000_1234_5678;
   localparam logic [WORD_W-1:0] RESET_B = 64'h0000_0000_8765_4321;

   localparam int ROT_SUM  = 17;
   localparam int ROT_A    = 49;
   localparam int SHL_T    = 21;
   localparam int ROT_T    = 28;
   localparam int MIX_SH1  = 30;
   localparam int MIX_SH2  = 27;
   localparam int MIX_SH3  = 31;

   typedef enum logic [1:0] {
      OP_SEED   = 2'd0,
      OP_RAW    = 2'd1,
      OP_FRAC   = 2'd2,
      OP_RANGED = 2'd3
   } op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int amt);
      rotl = (v << amt) | (v >> (WORD_W - amt));
   endfunction

endpackage

FILE: rtl/xpr_req_if.sv
// Request channel interface of the xoroshiro PRNG.
// Depends on xpr_pkg.
interface xpr_req_if;
   logic                              valid;
   logic                              ready;
   xpr_pkg::op_type                   op;
   logic        [xpr_pkg::WORD_W-1:0] seed_value;
   logic signed [xpr_pkg::WORD_W-1:0] range_low;
   logic signed [xpr_pkg::WORD_W-1:0] range_high;

   modport source (output valid, op, seed_value, range_low, range_high, input ready);
   modport sink   (input valid, op, seed_value, range_low, range_high, output ready);
endinterface

FILE: rtl/xpr_rsp_if.sv
// Response channel interface of the xoroshiro PRNG.
// Depends on xpr_pkg.
interface xpr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic        [xpr_pkg::WORD_W-1:0] random_bits;
   logic        [xpr_pkg::FRAC_W-1:0] fraction_bits;
   logic signed [xpr_pkg::WORD_W-1:0] ranged_value;

   modport source (output valid, random_bits, fraction_bits, ranged_value, input ready);
   modport sink   (input valid, random_bits, fraction_bits, ranged_value, output ready);
endinterface

FILE: rtl/xpr_serial_mult.sv
// Bit-serial 64x64 multiplier, low word of the product, one bit per cycle.
// Depends on xpr_pkg and the assertion macro header.
`include "xoroshiro_prng_ranged_defines.svh"

module xpr_serial_mult (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [xpr_pkg::WORD_W-1:0]   op_a,
   input  logic [xpr_pkg::WORD_W-1:0]   op_b,
   output logic [xpr_pkg::WORD_W-1:0]   product,
   output xpr_pkg::unit_status_type     status
);

   logic [xpr_pkg::WORD_W-1:0] mcand_ff, mcand_in;
   logic [xpr_pkg::WORD_W-1:0] mplier_ff, mplier_in;
   logic [xpr_pkg::WORD_W-1:0] acc_ff, acc_in;
   logic [xpr_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = op_a;
         mplier_in = op_b;
         acc_in    = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         // add shifted multiplicand when the current multiplier bit is set
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `XPR_ASSERT_IMP(a_mul_start_when_free, start, !busy_ff)
   `XPR_ASSERT_NEXT(a_mul_start_sets_busy, start, busy_ff && !done_ff)

endmodule

FILE: rtl/xpr_serial_mod.sv
// Restoring bit-serial remainder unit, 64-bit unsigned, one bit per cycle.
// Depends on xpr_pkg and the assertion macro header.
`include "xoroshiro_prng_ranged_defines.svh"

module xpr_serial_mod (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [xpr_pkg::WORD_W-1:0]   dividend,
   input  logic [xpr_pkg::WORD_W-1:0]   divisor,
   output logic [xpr_pkg::WORD_W-1:0]   remainder,
   output xpr_pkg::unit_status_type     status
);

   logic [xpr_pkg::WORD_W-1:0] quo_ff, quo_in;
   logic [xpr_pkg::WORD_W-1:0] div_ff, div_in;
   logic [xpr_pkg::WORD_W-1:0] rem_ff, rem_in;
   logic [xpr_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [xpr_pkg::WORD_W:0]   trial;
   logic [xpr_pkg::WORD_W:0]   diff;

   always_comb begin
      quo_in  = quo_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[xpr_pkg::WORD_W-1]};
      diff    = trial - {1'b0, div_ff};
      if (start) begin
         quo_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // borrow out of the trial subtract means keep the partial remainder
         rem_in = diff[xpr_pkg::WORD_W] ? trial[xpr_pkg::WORD_W-1:0]
                                        : diff[xpr_pkg::WORD_W-1:0];
         quo_in = quo_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `XPR_ASSERT_IMP(a_mod_done_not_busy, done_ff, !busy_ff)
   `XPR_ASSERT_NEXT(a_mod_start_sets_busy, start, busy_ff)

endmodule

FILE: rtl/xoroshiro_prng_ranged.sv
// Top level of the xoroshiro128++ generator with seed, raw, fraction and ranged ops.
// Depends on xpr_pkg, xpr_req_if, xpr_rsp_if, xpr_serial_mult, xpr_serial_mod.
//
// Usage:
//   req carries one operation per transfer (op, seed_value, range_low, range_high).
//   rsp carries one result per raw, fraction or ranged op; seed gives none.
//   Fields of a result that do not belong to its op read as zero.
//   One op is worked at a time; req.ready is high whenever the sequencer is idle,
//   also while a finished result still sits in the rsp register.
// Path from the transfer edge to rsp.valid (or to ready again for seed):
//   raw / fraction : generator step (S_GEN_SUM, S_GEN_OUT), then output load.
//   ranged         : swap, span, generator step, then 64-step serial remainder unit;
//                    span over the whole 64-bit range: low bound, no generator step.
//   seed           : four 64-step serial multiplies
//                    (two SplitMix64 rounds, each with two constant multiplies).
// Reset: synchronous, loads the state words with their fixed reset seeds
//   and empties the rsp register.
// Stall: if rsp.ready is low while the rsp register is full, the next result
//   waits in its final state; the op after it is not taken until it is loaded.
`include "xoroshiro_prng_ranged_defines.svh"

module xoroshiro_prng_ranged (
   input logic        clock,
   input logic        reset,
   xpr_req_if.sink    req,
   xpr_rsp_if.source  rsp
);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_MIX_ADD = 10'b00_0000_0010,
      S_MIX_M1  = 10'b00_0000_0100,
      S_MIX_M2  = 10'b00_0000_1000,
      S_SWAP    = 10'b00_0001_0000,
      S_SPAN    = 10'b00_0010_0000,
      S_GEN_SUM = 10'b00_0100_0000,
      S_GEN_OUT = 10'b00_1000_0000,
      S_MOD     = 10'b01_0000_0000,
      S_FINAL   = 10'b10_0000_0000
   } state_type;

   localparam int W = xpr_pkg::WORD_W;

   state_type       state_ff, state_in;
   xpr_pkg::op_type op_ff, op_in;
   logic [W-1:0]    word_a_ff, word_a_in;
   logic [W-1:0]    word_b_ff, word_b_in;
   logic [W-1:0]    mix_ff, mix_in;       // SplitMix input word
   logic            round_ff, round_in;   // second SplitMix round pending
   logic [W-1:0]    lo_ff, lo_in;
   logic [W-1:0]    hi_ff, hi_in;
   logic [W-1:0]    span_ff, span_in;
   logic [W-1:0]    sum_ff, sum_in;
   logic [W-1:0]    result_ff, result_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]           rsp_bits_ff, rsp_bits_in;
   logic [xpr_pkg::FRAC_W-1:0] rsp_frac_ff, rsp_frac_in;
   logic [W-1:0]           rsp_rng_ff, rsp_rng_in;

   logic                     mul_start;
   logic [W-1:0]             mul_a;
   logic [W-1:0]             mul_b;
   logic [W-1:0]             mul_p;
   xpr_pkg::unit_status_type mul_status;

   logic                     mod_start;
   logic [W-1:0]             mod_rem;
   xpr_pkg::unit_status_type mod_status;

   // scratch values
   logic [W-1:0] mix_z;
   logic [W-1:0] gen_r;
   logic [W-1:0] gen_t;
   logic         load_rsp;

   xpr_serial_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p),
      .status  (mul_status)
   );

   xpr_serial_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (gen_r),
      .divisor   (span_ff),
      .remainder (mod_rem),
      .status    (mod_status)
   );

   assign req.ready = (state_ff == S_IDLE);

   // second half of the generator step: output word and next state words
   assign gen_r = xpr_pkg::rotl(sum_ff, xpr_pkg::ROT_SUM) + word_a_ff;
   assign gen_t = word_b_ff ^ word_a_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      word_a_in = word_a_ff;
      word_b_in = word_b_ff;
      mix_in    = mix_ff;
      round_in  = round_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      span_in   = span_ff;
      sum_in    = sum_ff;
      result_in = result_ff;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = xpr_pkg::MIX_M1;
      mod_start = 1'b0;
      mix_z     = '0;
      load_rsp  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in    = req.op;
               mix_in   = req.seed_value;
               lo_in    = req.range_low;
               hi_in    = req.range_high;
               round_in = 1'b0;
               unique case (req.op)
                  xpr_pkg::OP_SEED:   state_in = S_MIX_ADD;
                  xpr_pkg::OP_RANGED: state_in = S_SWAP;
                  default:            state_in = S_GEN_SUM;
               endcase
            end
         end
         S_MIX_ADD: begin
            mix_z     = mix_ff + xpr_pkg::GOLDEN;
            mul_a     = mix_z ^ (mix_z >> xpr_pkg::MIX_SH1);
            mul_b     = xpr_pkg::MIX_M1;
            mul_start = 1'b1;
            state_in  = S_MIX_M1;
         end
         S_MIX_M1: begin
            if (mul_status.done) begin
               mul_a     = mul_p ^ (mul_p >> xpr_pkg::MIX_SH2);
               mul_b     = xpr_pkg::MIX_M2;
               mul_start = 1'b1;
               state_in  = S_MIX_M2;
            end
         end
         S_MIX_M2: begin
            if (mul_status.done) begin
               mix_z = mul_p ^ (mul_p >> xpr_pkg::MIX_SH3);
               if (!round_ff) begin
                  // word a done; word b is one more round on the new word a
                  word_a_in = mix_z;
                  mix_in    = mix_z;
                  round_in  = 1'b1;
                  state_in  = S_MIX_ADD;
               end else begin
                  word_b_in = mix_z;
                  state_in  = S_IDLE;
               end
            end
         end
         S_SWAP: begin
            if ($signed(lo_ff) > $signed(hi_ff)) begin
               lo_in = hi_ff;
               hi_in = lo_ff;
            end
            state_in = S_SPAN;
         end
         S_SPAN: begin
            span_in  = hi_ff - lo_ff + 1'b1;
            state_in = S_GEN_SUM;
         end
         S_GEN_SUM: begin
            if (op_ff == xpr_pkg::OP_RANGED && span_ff == '0) begin
               // full 64-bit span: low bound, generator left alone
               result_in = lo_ff;
               state_in  = S_FINAL;
            end else begin
               sum_in   = word_a_ff + word_b_ff;
               state_in = S_GEN_OUT;
            end
         end
         S_GEN_OUT: begin
            word_a_in = xpr_pkg::rotl(word_a_ff, xpr_pkg::ROT_A) ^ gen_t
                        ^ (gen_t << xpr_pkg::SHL_T);
            word_b_in = xpr_pkg::rotl(gen_t, xpr_pkg::ROT_T);
            result_in = gen_r;
            if (op_ff == xpr_pkg::OP_RANGED) begin
               mod_start = 1'b1;
               state_in  = S_MOD;
            end else begin
               state_in  = S_FINAL;
            end
         end
         S_MOD: begin
            if (mod_status.done) begin
               result_in = lo_ff + mod_rem;
               state_in  = S_FINAL;
            end
         end
         S_FINAL: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // rsp holding register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_bits_in  = rsp_bits_ff;
      rsp_frac_in  = rsp_frac_ff;
      rsp_rng_in   = rsp_rng_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_bits_in  = (op_ff == xpr_pkg::OP_RAW) ? result_ff : '0;
         rsp_frac_in  = (op_ff == xpr_pkg::OP_FRAC)
                        ? result_ff[W-1:xpr_pkg::FRAC_SHIFT] : '0;
         rsp_rng_in   = (op_ff == xpr_pkg::OP_RANGED) ? result_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         word_a_ff    <= xpr_pkg::RESET_A;
         word_b_ff    <= xpr_pkg::RESET_B;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_a_ff    <= word_a_in;
         word_b_ff    <= word_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      mix_ff      <= mix_in;
      round_ff    <= round_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      span_ff     <= span_in;
      sum_ff      <= sum_in;
      result_ff   <= result_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_frac_ff <= rsp_frac_in;
      rsp_rng_ff  <= rsp_rng_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.random_bits   = rsp_bits_ff;
   assign rsp.fraction_bits = rsp_frac_ff;
   assign rsp.ranged_value  = rsp_rng_ff;

   `XPR_ASSERT_IMP(a_idle_units_free, req.ready, !mul_status.busy && !mod_status.busy)
   `XPR_ASSERT_IMP(a_mul_done_in_mix, mul_status.done,
                   state_ff == S_MIX_M1 || state_ff == S_MIX_M2)

endmodule
